### hdl/ssgcd_pkg.sv
// Shared types and codes for the shift-subtract GCD block.
package ssgcd_pkg;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_ORDER = 6'b000010,
    ST_SHIFT = 6'b000100,
    ST_SUB1  = 6'b001000,
    ST_SUB2  = 6'b010000,
    ST_SUB3  = 6'b100000
  } state_e;

  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_LOAD  = 3'd1,
    OP_ORDER = 3'd2,
    OP_SHIFT = 3'd3,
    OP_SUB1  = 3'd4,
    OP_SUB2  = 3'd5,
    OP_SUB3  = 3'd6
  } op_e;

  typedef struct packed {
    logic lt;        // borrow of the shared subtractor
    logic min_zero;  // smaller operand is zero
  } ssgcd_stat_t;

endpackage

### hdl/ssgcd_datapath.sv
// Operand registers and the shared subtract/compare unit of the GCD block.
module ssgcd_datapath import ssgcd_pkg::*; #(
  parameter int unsigned WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  op_e              op_i,
  input  logic [WIDTH-1:0] value_a_i,
  input  logic [WIDTH-1:0] value_b_i,
  output ssgcd_stat_t      stat_o,
  output logic [WIDTH-1:0] max_o
);

  logic [WIDTH-1:0] a_q, a_d;
  logic [WIDTH-1:0] b_q, b_d;
  logic [WIDTH-1:0] bs_q, bs_d;
  logic [WIDTH-1:0] a_mag, b_mag;
  logic [WIDTH-1:0] min_val;
  logic [WIDTH:0]   sub_x, sub_y;
  logic [WIDTH+1:0] diff;
  logic             lt;

  assign a_mag = value_a_i[WIDTH-1] ? ('0 - value_a_i) : value_a_i;
  assign b_mag = value_b_i[WIDTH-1] ? ('0 - value_b_i) : value_b_i;

  // single shared subtractor, operands chosen per step
  always_comb begin
    sub_x = {1'b0, a_q};
    sub_y = {1'b0, b_q};
    case (op_i)
      OP_SHIFT: sub_y = {bs_q, 1'b0};
      OP_SUB1:  sub_y = {1'b0, bs_q};
      OP_SUB2: begin
        sub_x = {1'b0, bs_q};
        sub_y = {1'b0, a_q};
      end
      OP_SUB3:  sub_y = {1'b0, bs_q};
      default: begin
        sub_x = {1'b0, a_q};
        sub_y = {1'b0, b_q};
      end
    endcase
  end

  assign diff    = {1'b0, sub_x} - {1'b0, sub_y};
  assign lt      = diff[WIDTH+1];
  assign min_val = lt ? a_q : b_q;
  assign max_o   = lt ? b_q : a_q;

  assign stat_o.lt       = lt;
  assign stat_o.min_zero = (min_val == '0);

  always_comb begin
    a_d  = a_q;
    b_d  = b_q;
    bs_d = bs_q;
    case (op_i)
      OP_LOAD: begin
        a_d = a_mag;
        b_d = b_mag;
      end
      OP_ORDER: begin
        a_d  = max_o;
        b_d  = min_val;
        bs_d = min_val;
      end
      OP_SHIFT: if (!lt) bs_d = {bs_q[WIDTH-2:0], 1'b0};
      OP_SUB1:  a_d  = diff[WIDTH-1:0];
      OP_SUB2:  bs_d = diff[WIDTH-1:0];
      OP_SUB3:  a_d  = lt ? a_q : bs_q;
      default: begin
        a_d  = a_q;
        b_d  = b_q;
        bs_d = bs_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    a_q  <= a_d;
    b_q  <= b_d;
    bs_q <= bs_d;
  end

  a_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(op_i == OP_ORDER) |-> (a_q >= b_q))
    else $error("operands not ordered");

  a_shift_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == OP_SHIFT) |-> (bs_q <= a_q))
    else $error("shifted divisor above dividend");

  a_low_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(op_i == OP_SUB1) |-> (a_q < bs_q))
    else $error("remainder not below shifted divisor");

endmodule

### hdl/shift_subtract_gcd.sv
// Top level of the shift-subtract GCD block: sequencer and result register.
//
// Usage: drive value_a_i and value_b_i (two's complement) and raise start;
// the item is taken at a clock edge where start is high and busy is low.
// busy stays high while the item is worked on. The result gcd_value_o is
// valid for exactly one cycle, marked by strobe_o; busy is already low in
// that cycle, so the next item may be started alongside it.
// Sequence: a load step, then per reduction round an ordering step, the
// alignment shift steps (the divisor doubles while twice it still fits the
// larger operand), the subtract steps SUB1, SUB2 and SUB3, and a final
// ordering step. A round that leaves the pair in order hands its shift on,
// but one that swaps the pair can start the next round with a shift only
// two below its own, so the shifts can add up to nearly WIDTH*WIDTH/4. An
// item with a zero operand ends at its first ordering step. The rate is set
// by the one shared subtractor.
// Reset returns the sequencer to idle and clears the strobe; an item in
// flight is dropped. The receiver cannot stall: results are never held.
module shift_subtract_gcd import ssgcd_pkg::*; #(
  parameter int unsigned WIDTH = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  input  logic signed [WIDTH-1:0] value_a_i,
  input  logic signed [WIDTH-1:0] value_b_i,
  output logic                    busy,
  output logic                    strobe_o,
  output logic        [WIDTH-1:0] gcd_value_o
);

  state_e           state_q, state_d;
  op_e              op;
  ssgcd_stat_t      stat;
  logic [WIDTH-1:0] dp_max;
  logic [WIDTH-1:0] gcd_q, gcd_d;
  logic             strobe_q, strobe_d;

  ssgcd_datapath #(
    .WIDTH (WIDTH)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .op_i      (op),
    .value_a_i (value_a_i),
    .value_b_i (value_b_i),
    .stat_o    (stat),
    .max_o     (dp_max)
  );

  always_comb begin
    state_d  = state_q;
    op       = OP_NONE;
    strobe_d = 1'b0;
    gcd_d    = gcd_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          op      = OP_LOAD;
          state_d = ST_ORDER;
        end
      end
      ST_ORDER: begin
        op = OP_ORDER;
        if (stat.min_zero) begin
          state_d  = ST_IDLE;
          strobe_d = 1'b1;
          gcd_d    = dp_max;
        end else begin
          state_d = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        op = OP_SHIFT;
        if (stat.lt) state_d = ST_SUB1;
      end
      ST_SUB1: begin
        op      = OP_SUB1;
        state_d = ST_SUB2;
      end
      ST_SUB2: begin
        op      = OP_SUB2;
        state_d = ST_SUB3;
      end
      ST_SUB3: begin
        op      = OP_SUB3;
        state_d = ST_ORDER;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    gcd_q <= gcd_d;
  end

  assign busy        = (state_q != ST_IDLE);
  assign strobe_o    = strobe_q;
  assign gcd_value_o = gcd_q;

  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> !busy)
    else $error("result strobe while busy");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_done_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> strobe_o)
    else $error("item finished without a result");

endmodule

### verif/shift_subtract_gcd_tb.sv
// Self-checking testbench for shift_subtract_gcd: directed and random operand pairs.
module shift_subtract_gcd_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned W           = 32;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned DRAIN       = 250;
  localparam int unsigned RAND_ITEMS  = 230;

  typedef struct {
    logic [W-1:0] a;
    logic [W-1:0] b;
  } operand_pair_t;

  typedef struct {
    logic [W-1:0] a;
    logic [W-1:0] b;
    logic [W-1:0] gcd;
  } gcd_due_t;

  typedef enum int {
    MIX_RAW,
    MIX_SHARED,
    MIX_EDGE,
    MIX_POW2,
    MIX_TINY,
    MIX_MULTIPLE
  } pair_mix_e;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         start = 1'b0;
  logic [W-1:0] value_a_i = '0;
  logic [W-1:0] value_b_i = '0;
  logic         busy;
  logic         strobe_o;
  logic [W-1:0] gcd_value_o;

  operand_pair_t pending_pairs[$];
  gcd_due_t      gcd_due[$];
  int unsigned   send_idle_pct = 37;
  int unsigned   mismatch_count = 0;
  int unsigned   cycle_count = 0;

  shift_subtract_gcd #(.WIDTH(W)) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .value_a_i  (value_a_i),
    .value_b_i  (value_b_i),
    .busy       (busy),
    .strobe_o   (strobe_o),
    .gcd_value_o(gcd_value_o)
  );

  always #5 clk_i = ~clk_i;

  // gcd of the two's complement magnitudes by shift-and-subtract reduction
  function automatic logic [W-1:0] signed_pair_gcd(logic [W-1:0] x, logic [W-1:0] y);
    logic [63:0] big;
    logic [63:0] tiny;
    logic [63:0] rest_lo;
    logic [63:0] rest_hi;
    logic [63:0] tmp;
    int unsigned sh;
    big  = x[W-1] ? (64'd1 << W) - 64'(x) : 64'(x);
    tiny = y[W-1] ? (64'd1 << W) - 64'(y) : 64'(y);
    if (big < tiny) begin
      tmp  = big;
      big  = tiny;
      tiny = tmp;
    end
    while (tiny != 0) begin
      sh = 0;
      while ((tiny << (sh + 1)) <= big) sh++;
      rest_lo = big - (tiny << sh);
      rest_hi = (tiny << (sh + 1)) - big;
      big     = tiny;
      tiny    = (rest_lo < rest_hi) ? rest_lo : rest_hi;
      if (big < tiny) begin
        tmp  = big;
        big  = tiny;
        tiny = tmp;
      end
    end
    return big[W-1:0];
  endfunction

  task automatic flag_mismatch(string msg);
    $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  task automatic push_pair(logic [W-1:0] a, logic [W-1:0] b);
    operand_pair_t p;
    p.a = a;
    p.b = b;
    pending_pairs.push_back(p);
  endtask

  task automatic push_random(int unsigned count);
    logic [W-1:0] a;
    logic [W-1:0] b;
    logic [W-1:0] g;
    pair_mix_e    mix;
    for (int unsigned i = 0; i < count; i++) begin
      mix = pair_mix_e'($urandom_range(0, 5));
      case (mix)
        MIX_RAW: begin
          a = $urandom;
          b = $urandom;
        end
        MIX_SHARED: begin
          g = $urandom_range(1, 65535);
          a = g * $urandom_range(0, 32767);
          b = g * $urandom_range(0, 32767);
        end
        MIX_EDGE: begin
          a = $urandom;
          case ($urandom_range(0, 4))
            0:       b = '0;
            1:       b = {1'b1, {(W-1){1'b0}}};
            2:       b = {1'b0, {(W-1){1'b1}}};
            3:       b = '1;
            default: b = 1;
          endcase
        end
        MIX_POW2: begin
          a = $urandom_range(1, 255) << $urandom_range(0, W - 1);
          b = $urandom_range(1, 255) << $urandom_range(0, W - 1);
        end
        MIX_TINY: begin
          a = $urandom_range(0, 255);
          b = $urandom_range(0, 255);
        end
        default: begin
          b = $urandom >> $urandom_range(0, W - 1);
          a = b * $urandom_range(1, 1000);
        end
      endcase
      if ($urandom_range(0, 1)) a = -a;
      if ($urandom_range(0, 1)) b = -b;
      if ($urandom_range(0, 1)) push_pair(a, b);
      else push_pair(b, a);
    end
  endtask

  always @(posedge clk_i) begin : drive_items
    operand_pair_t next_pair;
    gcd_due_t      due;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        due.a   = value_a_i;
        due.b   = value_b_i;
        due.gcd = signed_pair_gcd(value_a_i, value_b_i);
        gcd_due.push_back(due);
      end
      if (!start || !busy) begin
        if (pending_pairs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_pair = pending_pairs.pop_front();
          start     <= 1'b1;
          value_a_i <= next_pair.a;
          value_b_i <= next_pair.b;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    gcd_due_t due;
    if (rst_ni && strobe_o) begin
      if (gcd_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected result gcd_value %0d", gcd_value_o));
      end else begin
        due = gcd_due.pop_front();
        if (gcd_value_o !== due.gcd)
          flag_mismatch($sformatf("gcd(%0d, %0d): gcd_value %0d, want %0d",
                                  $signed(due.a), $signed(due.b), gcd_value_o, due.gcd));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("shift_subtract_gcd_tb: done, errors");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // zeros, extremes, equal operands, coprime and Fibonacci pairs
    push_pair(0, 0);
    push_pair(0, 5);
    push_pair(5, 0);
    push_pair(32'h8000_0000, 0);
    push_pair(0, 32'h8000_0000);
    push_pair(32'h8000_0000, 32'h8000_0000);
    push_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_pair(32'h7FFF_FFFF, 32'h8000_0000);
    push_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_pair(1, 32'hFFFF_FFFF);
    push_pair(32'h8000_0000, 6);
    push_pair(12, 18);
    push_pair(-48, 180);
    push_pair(17, 13);
    push_pair(32'h7FFF_FFFF, 1);
    push_pair(1, 32'h7FFF_FFFF);
    push_pair(32'h7FFF_FFFF, 32'h7FFF_FFFE);
    push_pair(1836311903, 1134903170);
    push_pair(-1134903170, 1836311903);
    push_pair(65536 * 3, 65536 * 9);
    push_pair(123456, 123456);
    push_pair(-6, -4);
    push_pair(32'h5555_5555, 32'hAAAA_AAAA);
    push_random(RAND_ITEMS);
    while (pending_pairs.size() != 0 || start) @(posedge clk_i);

    send_idle_pct = 55;
    push_random(RAND_ITEMS);
    while (pending_pairs.size() != 0 || start) @(posedge clk_i);

    send_idle_pct = 0;
    push_random(RAND_ITEMS);
    while (pending_pairs.size() != 0 || start || gcd_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("shift_subtract_gcd_tb: done, clean");
    end else begin
      $display("shift_subtract_gcd_tb: done, errors");
    end
    $finish;
  end

endmodule
